// ===== rtl/lcddr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lcddr_pkg;

   localparam int MaxColumns = 132;
   localparam int MaxPages   = 9;
   localparam int MaxWords   = 5;
   localparam int CountWidth = $clog2(MaxWords + 1);

   localparam logic [7:0] CMD_PAGE    = 8'hB0;
   localparam logic [7:0] CMD_COL_HI  = 8'h10;
   localparam logic [7:0] CMD_COL_LO  = 8'h00;
   localparam logic [7:0] NIBBLE_MASK = 8'h0F;
   localparam logic [7:0] CMD_NOP     = 8'hE3;

   typedef enum logic {
      CSR_START_COLUMN = 1'b0,
      CSR_SOFT_INVERT  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_data;
   } rsp_word_type;

   typedef rsp_word_type [MaxWords-1:0] word_list_type;

   typedef struct packed {
      word_list_type         words;
      logic [CountWidth-1:0] count;
   } burst_type;

endpackage : lcddr_pkg

`default_nettype wire

// ===== rtl/lcddr_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lcddr_tracker
   import lcddr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [3:0] page,
   input  wire logic [7:0] column,
   input  wire logic       changed,
   input  wire logic [7:0] pixel_byte,
   input  wire logic       frame_end,
   input  wire logic [6:0] start_column,
   input  wire logic       soft_invert,
   output burst_type       burst
);

   logic       page_started_ff;
   logic       page_started_in;
   logic [7:0] prev_col_ff;
   logic [7:0] prev_col_in;

   logic       started_eff;
   logic       in_range;
   logic       do_write;
   logic       contiguous;
   logic [7:0] addr;
   logic [7:0] data_byte;

   assign started_eff = page_started_ff && (column != 8'd0);
   assign in_range    = ({1'b0, page} < 5'(MaxPages)) && ({1'b0, column} < 9'(MaxColumns));
   assign do_write    = changed && in_range;
   assign contiguous  = started_eff && ({1'b0, column} == ({1'b0, prev_col_ff} + 9'd1));
   assign addr        = {1'b0, start_column} + column;
   assign data_byte   = soft_invert ? ~pixel_byte : pixel_byte;

   // pack the words of this item in send order
   always_comb begin
      logic [CountWidth-1:0] idx;
      idx = '0;
      burst.words = '0;
      if (do_write && !contiguous && !started_eff) begin
         burst.words[idx] = '{out_byte: CMD_PAGE | {4'd0, page}, is_data: 1'b0};
         idx = idx + 1'b1;
      end
      if (do_write && !contiguous) begin
         burst.words[idx] = '{out_byte: CMD_COL_LO | (addr & NIBBLE_MASK), is_data: 1'b0};
         idx = idx + 1'b1;
         burst.words[idx] = '{out_byte: CMD_COL_HI | {4'd0, addr[7:4]}, is_data: 1'b0};
         idx = idx + 1'b1;
      end
      if (do_write) begin
         burst.words[idx] = '{out_byte: data_byte, is_data: 1'b1};
         idx = idx + 1'b1;
      end
      if (frame_end) begin
         burst.words[idx] = '{out_byte: CMD_NOP, is_data: 1'b0};
         idx = idx + 1'b1;
      end
      burst.count = idx;
   end

   always_comb begin
      page_started_in = page_started_ff;
      prev_col_in     = prev_col_ff;
      if (accept) begin
         page_started_in = do_write ? 1'b1 : started_eff;
         prev_col_in     = do_write ? column : prev_col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_started_ff <= 1'b0;
         prev_col_ff     <= 8'd0;
      end else begin
         page_started_ff <= page_started_in;
         prev_col_ff     <= prev_col_in;
      end
   end

endmodule : lcddr_tracker

`default_nettype wire

// ===== rtl/lcddr_burst_out.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lcddr_burst_out
   import lcddr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  burst_type       burst,
   output logic            load_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_is_data,
   output logic            rsp_run_last
);

   word_list_type         words_ff;
   word_list_type         words_in;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic                  pop;

   assign rsp_valid    = (count_ff != '0);
   assign pop          = rsp_valid && rsp_ready;
   assign load_ready   = (count_ff == '0) || ((count_ff == CountWidth'(1)) && rsp_ready);
   assign rsp_out_byte = words_ff[0].out_byte;
   assign rsp_is_data  = words_ff[0].is_data;
   assign rsp_run_last = (count_ff == CountWidth'(1));

   always_comb begin
      words_in = words_ff;
      count_in = count_ff;
      if (load) begin
         words_in = burst.words;
         count_in = burst.count;
      end else if (pop) begin
         for (int i = 0; i < MaxWords - 1; i++) begin
            words_in[i] = words_ff[i+1];
         end
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      words_ff <= words_in;
   end

endmodule : lcddr_burst_out

`default_nettype wire

// ===== rtl/lcd_dirty_refresh_sequencer_unit.sv =====
// channel  direction  ports                                          handshake
// req      in         req_page req_column req_changed                 req_valid/req_ready
//                     req_pixel_byte req_frame_end
// rsp      out        rsp_out_byte rsp_is_data rsp_run_last           rsp_valid/rsp_ready
// csr      in         csr_index csr_wdata                             csr_write_en
//
// an item is decoded in its accept cycle; its zero to five words leave one per cycle while
// rsp_ready is high; a run of contiguous changed columns moves at one item per cycle while
// rsp_ready is high; an item with more than one word (address commands or a frame-end
// nop) holds req_ready low until its last word is taken
// the next item is taken in the cycle its predecessor's last word is taken
// synchronous reset clears the page tracking, the word count and both csr registers
`timescale 1ns / 1ps
`default_nettype none

module lcd_dirty_refresh_sequencer_unit
   import lcddr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [3:0] req_page,
   input  wire logic [7:0] req_column,
   input  wire logic       req_changed,
   input  wire logic [7:0] req_pixel_byte,
   input  wire logic       req_frame_end,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_is_data,
   output logic            rsp_run_last,
   input  wire logic       csr_write_en,
   input  wire logic       csr_index,
   input  wire logic [6:0] csr_wdata
);

   logic [6:0] start_column_ff;
   logic [6:0] start_column_in;
   logic       soft_invert_ff;
   logic       soft_invert_in;
   logic       accept;
   burst_type  burst;

   assign accept = req_valid && req_ready;

   always_comb begin
      start_column_in = start_column_ff;
      soft_invert_in  = soft_invert_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_START_COLUMN: start_column_in = csr_wdata;
            CSR_SOFT_INVERT:  soft_invert_in  = csr_wdata[0];
            default:          start_column_in = start_column_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_column_ff <= 7'd0;
         soft_invert_ff  <= 1'b0;
      end else begin
         start_column_ff <= start_column_in;
         soft_invert_ff  <= soft_invert_in;
      end
   end

   lcddr_tracker u_tracker (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .page         (req_page),
      .column       (req_column),
      .changed      (req_changed),
      .pixel_byte   (req_pixel_byte),
      .frame_end    (req_frame_end),
      .start_column (start_column_ff),
      .soft_invert  (soft_invert_ff),
      .burst        (burst)
   );

   lcddr_burst_out u_burst_out (
      .clock        (clock),
      .reset        (reset),
      .load         (accept),
      .burst        (burst),
      .load_ready   (req_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_is_data  (rsp_is_data),
      .rsp_run_last (rsp_run_last)
   );

endmodule : lcd_dirty_refresh_sequencer_unit

`default_nettype wire
